// ----- rtl/core/spjq_pkg.sv -----
package spjq_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_HEAD   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_PUT,
    S_CMP_RD,
    S_CMP_CHK
  } state_e;

  localparam int JOB_W = 16;
  localparam int PRIO_W = 8;
  localparam int CNT_OUT_W = 5;

  typedef struct packed {
    op_e               op;
    logic [JOB_W-1:0]  job_id;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [JOB_W-1:0]     head_job;
    logic [PRIO_W-1:0]    head_prio;
    logic [CNT_OUT_W-1:0] removed_count;
    logic [CNT_OUT_W-1:0] occupancy;
  } result_t;

  // One queue entry as held in the RAM
  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/core/spjq_ram.sv -----
module spjq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sorted_priority_job_queue.sv -----
// Sorted priority job queue.
// Holds up to DEPTH jobs sorted by ascending priority; equal priorities keep
// arrival order. Entries live in a single-port-write, registered-read RAM and
// are walked by a small sequencer, one RAM read and one compare per step.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// busy stays high while an operation walks the RAM.
// Result channel: result is valid for exactly one cycle with done high; there
// is no back-pressure, the receiver must take it in that cycle.
// Per command: add walks from the tail toward the head, shifting each entry
// of higher priority one place toward the tail, and stops on a lower or equal
// priority or at the head; remove head and remove by number walk every filled
// entry; full add, empty remove head and op 3 finish straight from idle.
// Each step takes a read state and a compare state because the RAM read data
// is registered before the compare. A new command may be sent in the cycle
// done is high. Reset empties the queue (fill count to zero); RAM contents
// are not cleared and entries beyond the fill count are never used.
module sorted_priority_job_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spjq_pkg::cmd_t    cmd,
  output logic              done,
  output spjq_pkg::result_t result
);
  import spjq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_e            state, state_next;
  cmd_t              cmd_q, cmd_q_next;
  logic [CW-1:0]     fill, fill_next;
  logic [CW-1:0]     pos, pos_next;
  logic [CW-1:0]     wr, wr_next;
  logic [CW-1:0]     removed, removed_next;
  entry_t            head, head_next;
  result_t           result_next;
  logic              done_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [CW-1:0]     pos_dec, pos_inc, fill_inc;
  logic              accept, skip;
  entry_t            new_entry;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign pos_dec   = pos - 1'b1;
  assign pos_inc   = pos + 1'b1;
  assign fill_inc  = fill + 1'b1;
  assign rd_entry  = entry_t'(ram_rdata);
  assign new_entry = '{job: cmd_q.job_id, prio: cmd_q.prio};

  // Entry dropped by the compaction walk
  assign skip = ((cmd_q.op == OP_HEAD) && (pos == '0)) ||
                ((cmd_q.op == OP_REMOVE) && (rd_entry.job == cmd_q.job_id));

  spjq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    cmd_q   <= cmd_q_next;
    pos     <= pos_next;
    wr      <= wr_next;
    removed <= removed_next;
    head    <= head_next;
    result  <= result_next;
  end

  // Sequencer
  always_comb begin
    state_next   = state;
    cmd_q_next   = cmd_q;
    fill_next    = fill;
    pos_next     = pos;
    wr_next      = wr;
    removed_next = removed;
    head_next    = head;
    result_next  = result;
    done_next    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos[AW-1:0];
    ram_wdata    = rd_entry;
    ram_raddr    = pos_dec[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q_next   = cmd;
          pos_next     = '0;
          wr_next      = '0;
          removed_next = '0;
          head_next    = '0;
          result_next  = '{status: ST_OK, head_job: '0, head_prio: '0,
                            removed_count: '0, occupancy: CNT_OUT_W'(fill)};
          case (cmd.op)
            OP_ADD: begin
              if (fill == CW'(DEPTH)) begin
                result_next.status = ST_FULL;
                done_next          = 1'b1;
              end else if (fill == '0) begin
                pos_next   = '0;
                state_next = S_ADD_PUT;
              end else begin
                pos_next   = fill;
                state_next = S_ADD_RD;
              end
            end
            OP_HEAD: begin
              if (fill == '0) begin
                result_next.status = ST_EMPTY;
                done_next          = 1'b1;
              end else begin
                state_next = S_CMP_RD;
              end
            end
            OP_REMOVE: begin
              state_next = S_CMP_RD;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // Insertion walk from the tail toward the head
      S_ADD_RD: begin
        ram_raddr  = pos_dec[AW-1:0];
        state_next = S_ADD_CHK;
      end

      S_ADD_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = pos[AW-1:0];
        if (rd_entry.prio > cmd_q.prio) begin
          ram_wdata  = rd_entry;
          pos_next   = pos_dec;
          state_next = (pos_dec == '0) ? S_ADD_PUT : S_ADD_RD;
        end else begin
          ram_wdata   = new_entry;
          fill_next   = fill_inc;
          result_next.occupancy = CNT_OUT_W'(fill_inc);
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      S_ADD_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos[AW-1:0];
        ram_wdata   = new_entry;
        fill_next   = fill_inc;
        result_next.occupancy = CNT_OUT_W'(fill_inc);
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      // Compaction walk from the head toward the tail
      S_CMP_RD: begin
        ram_raddr = pos[AW-1:0];
        if (pos == fill) begin
          fill_next = wr;
          result_next.occupancy     = CNT_OUT_W'(wr);
          result_next.removed_count = CNT_OUT_W'(removed);
          result_next.head_job      = head.job;
          result_next.head_prio     = head.prio;
          if ((cmd_q.op == OP_REMOVE) && (removed == '0)) begin
            result_next.status = ST_NOT_FOUND;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CMP_CHK;
        end
      end

      S_CMP_CHK: begin
        ram_waddr = wr[AW-1:0];
        ram_wdata = rd_entry;
        if ((cmd_q.op == OP_HEAD) && (pos == '0)) begin
          head_next = rd_entry;
        end
        if (skip) begin
          removed_next = removed + 1'b1;
        end else begin
          ram_we  = 1'b1;
          wr_next = wr + 1'b1;
        end
        pos_next   = pos_inc;
        state_next = S_CMP_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command in flight");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> (fill == CW'(DEPTH)))
    else $error("add dropped while queue not full");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP_CHK) |-> ((wr <= pos) && (pos < fill)))
    else $error("compaction write pointer passed read pointer");

  a_add_grow: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ADD_PUT) || ((state == S_ADD_CHK) && !(rd_entry.prio > cmd_q.prio)))
    |=> (fill == $past(fill_inc)))
    else $error("insertion did not grow the queue by one");

endmodule
